### src/slqs_pkg.sv
// Package for the sparse LED quadrant scanner: item structs, action codes,
// controller states and fixed constants. No dependencies.
`timescale 1ns / 1ps

package slqs_pkg;

    localparam int C_QUAD_SIDE = 8;      // default quadrant side
    localparam int C_NUM_QUADS = 4;
    localparam int C_LOC_W     = 3;      // local coordinate width on the decoder pins
    localparam int C_FIELD_W   = 4;      // global coordinate width (16x16 field)
    localparam int C_PORT_W    = 6;
    localparam int C_BMP_DEPTH = 256;

    typedef enum logic [1:0] {
        ACT_WRITE  = 2'd0,
        ACT_COMMIT = 2'd1,
        ACT_TICK   = 2'd2,
        ACT_CORNER = 2'd3
    } t_act;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_COMMIT,
        ST_TICK
    } t_state;

    typedef struct packed {
        logic [1:0] action;
        logic [3:0] pixel_x;
        logic [3:0] pixel_y;
        logic       pixel_on;
    } t_in_item;

    typedef struct packed {
        logic [5:0] port_top_left;
        logic [5:0] port_bottom_left;
        logic [5:0] port_top_right;
        logic [5:0] port_bottom_right;
        logic [3:0] empty_flags;
    } t_out_item;

    localparam logic [5:0] C_CORNER_TL = 6'h00;
    localparam logic [5:0] C_CORNER_BL = 6'h38;
    localparam logic [5:0] C_CORNER_TR = 6'h07;
    localparam logic [5:0] C_CORNER_BR = 6'h3F;

endpackage

### src/slqs_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module slqs_ram #(
    parameter int P_WIDTH = 6,
    parameter int P_DEPTH = 64
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_waddr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    input  logic                       i_re,
    input  logic [$clog2(P_DEPTH)-1:0] i_raddr,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/sparse_led_quadrant_scanner.sv
// Top level of the sparse LED quadrant scanner: staging bitmap RAM, four
// lit-position list RAMs, per-quadrant counts and scan indices.
// Depends on slqs_pkg and slqs_ram.
`timescale 1ns / 1ps
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
//
//  Corner: result registered at accept.
//  Tick: bounded by the registered read of the list RAMs.
//  Commit: one bitmap RAM read per pixel.
//  After reset the bitmap is cleared one entry a cycle, all 256 entries, with input stalled.
//  Any item is taken only when the output register is free or draining.

module sparse_led_quadrant_scanner #(
    parameter int QUADRANT_SIDE = slqs_pkg::C_QUAD_SIDE
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  slqs_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output slqs_pkg::t_out_item o_out_item
);

    import slqs_pkg::*;

    localparam int L_DEPTH = QUADRANT_SIDE * QUADRANT_SIDE;
    localparam int AW      = $clog2(L_DEPTH);
    localparam int CW      = $clog2(L_DEPTH + 1);
    localparam int BAW     = $clog2(C_BMP_DEPTH);
    localparam logic [C_LOC_W-1:0]   L_LAST = C_LOC_W'(QUADRANT_SIDE - 1);
    localparam logic [C_FIELD_W-1:0] L_OFF  = C_FIELD_W'(QUADRANT_SIDE);

    t_state r_state, n_state;

    logic [BAW-1:0]     r_clr_addr;
    logic               r_cm_busy;
    logic [1:0]         r_cm_q;
    logic [C_LOC_W-1:0] r_cm_lx, r_cm_ly;
    logic               r_d_vld;
    logic [1:0]         r_d_q;
    logic [C_LOC_W-1:0] r_d_lx, r_d_ly;
    logic [CW-1:0]      r_fill;
    logic [CW-1:0]      r_cnt [C_NUM_QUADS];
    logic [AW-1:0]      r_idx [C_NUM_QUADS];
    logic               r_out_vld;
    t_out_item          r_out;

    logic               out_free, accept;
    logic               bm_we, bm_re;
    logic [BAW-1:0]     bm_waddr, bm_raddr;
    logic [0:0]         bm_wdata, bm_rdata;
    logic               list_re;
    logic [AW-1:0]      tick_idx [C_NUM_QUADS];
    logic [C_PORT_W-1:0] list_rdata [C_NUM_QUADS];
    logic [C_NUM_QUADS-1:0] list_we;
    logic [3:0]         empty;
    logic               cm_last, d_quad_last, d_done;
    logic [C_FIELD_W-1:0] cm_gx, cm_gy;

    assign out_free = !r_out_vld || !i_out_stall;
    assign accept   = i_in_valid && !o_in_stall;

    assign cm_last     = (r_cm_q == 2'd3) && (r_cm_lx == L_LAST) && (r_cm_ly == L_LAST);
    assign d_quad_last = (r_d_lx == L_LAST) && (r_d_ly == L_LAST);
    assign d_done      = r_d_vld && d_quad_last && (r_d_q == 2'd3);

    // quadrant 0 top-left, 1 bottom-left, 2 top-right, 3 bottom-right
    assign cm_gx = (r_cm_q[1] ? L_OFF : '0) + C_FIELD_W'(r_cm_lx);
    assign cm_gy = (r_cm_q[0] ? L_OFF : '0) + C_FIELD_W'(r_cm_ly);

    always_comb begin
        for (int q = 0; q < C_NUM_QUADS; q++) begin
            logic [AW:0] nx;
            nx = {1'b0, r_idx[q]} + 1'b1;
            tick_idx[q] = (nx < (AW+1)'(r_cnt[q])) ? nx[AW-1:0] : '0;
            empty[q]    = (r_cnt[q] == '0);
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BAW'(C_BMP_DEPTH - 1)) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept && i_in_item.action == ACT_COMMIT) n_state = ST_COMMIT;
                else if (accept && i_in_item.action == ACT_TICK) n_state = ST_TICK;
            end
            ST_COMMIT: begin
                if (d_done) n_state = ST_IDLE;
            end
            ST_TICK: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and RAM controls; in idle an item is taken when the output is free
    always_comb begin
        o_in_stall = 1'b1;
        bm_we      = 1'b0;
        bm_waddr   = r_clr_addr;
        bm_wdata   = 1'b0;
        bm_re      = 1'b0;
        bm_raddr   = {cm_gy, cm_gx};
        list_re    = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                bm_we = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = !out_free;
                bm_we    = i_in_valid && out_free && (i_in_item.action == ACT_WRITE);
                bm_waddr = {i_in_item.pixel_y, i_in_item.pixel_x};
                bm_wdata = i_in_item.pixel_on;
                list_re  = i_in_valid && out_free && (i_in_item.action == ACT_TICK);
            end
            ST_COMMIT: begin
                bm_re = r_cm_busy;
            end
            ST_TICK: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        for (int q = 0; q < C_NUM_QUADS; q++) begin
            list_we[q] = r_d_vld && bm_rdata[0] && (r_d_q == 2'(q));
        end
    end

    slqs_ram #(
        .P_WIDTH (1),
        .P_DEPTH (C_BMP_DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (bm_we),
        .i_waddr (bm_waddr),
        .i_wdata (bm_wdata),
        .i_re    (bm_re),
        .i_raddr (bm_raddr),
        .o_rdata (bm_rdata)
    );

    for (genvar g = 0; g < C_NUM_QUADS; g++) begin : g_list
        slqs_ram #(
            .P_WIDTH (C_PORT_W),
            .P_DEPTH (L_DEPTH)
        ) u_list (
            .i_clk   (i_clk),
            .i_we    (list_we[g]),
            .i_waddr (r_fill[AW-1:0]),
            .i_wdata ({r_d_ly, r_d_lx}),
            .i_re    (list_re),
            .i_raddr (tick_idx[g]),
            .o_rdata (list_rdata[g])
        );
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_cm_busy  <= 1'b0;
            r_d_vld    <= 1'b0;
            r_out_vld  <= 1'b0;
            for (int q = 0; q < C_NUM_QUADS; q++) begin
                r_cnt[q] <= '0;
                r_idx[q] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;

            if (list_re) begin
                for (int q = 0; q < C_NUM_QUADS; q++) r_idx[q] <= tick_idx[q];
            end

            if (accept && i_in_item.action == ACT_COMMIT) begin
                r_cm_busy <= 1'b1;
            end else if (r_cm_busy && cm_last) begin
                r_cm_busy <= 1'b0;
            end
            r_d_vld <= (r_state == ST_COMMIT) && r_cm_busy;

            // count lands when the last pixel of a quadrant comes back
            if (r_d_vld && d_quad_last) r_cnt[r_d_q] <= r_fill + CW'(bm_rdata[0]);

            if ((accept && i_in_item.action == ACT_CORNER) ||
                (r_state == ST_TICK && out_free)) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept && i_in_item.action == ACT_COMMIT) begin
            r_cm_q  <= '0;
            r_cm_lx <= '0;
            r_cm_ly <= '0;
            r_fill  <= '0;
        end else begin
            if (r_state == ST_COMMIT && r_cm_busy) begin
                if (r_cm_lx != L_LAST) begin
                    r_cm_lx <= r_cm_lx + 1'b1;
                end else begin
                    r_cm_lx <= '0;
                    if (r_cm_ly != L_LAST) begin
                        r_cm_ly <= r_cm_ly + 1'b1;
                    end else begin
                        r_cm_ly <= '0;
                        r_cm_q  <= r_cm_q + 1'b1;
                    end
                end
            end
            if (r_d_vld) begin
                if (d_quad_last) r_fill <= '0;
                else             r_fill <= r_fill + CW'(bm_rdata[0]);
            end
        end
        r_d_q  <= r_cm_q;
        r_d_lx <= r_cm_lx;
        r_d_ly <= r_cm_ly;

        if (accept && i_in_item.action == ACT_CORNER) begin
            r_out.port_top_left     <= C_CORNER_TL;
            r_out.port_bottom_left  <= C_CORNER_BL;
            r_out.port_top_right    <= C_CORNER_TR;
            r_out.port_bottom_right <= C_CORNER_BR;
            r_out.empty_flags       <= empty;
        end else if (r_state == ST_TICK && out_free) begin
            r_out.port_top_left     <= empty[0] ? '0 : list_rdata[0];
            r_out.port_bottom_left  <= empty[1] ? '0 : list_rdata[1];
            r_out.port_top_right    <= empty[2] ? '0 : list_rdata[2];
            r_out.port_bottom_right <= empty[3] ? '0 : list_rdata[3];
            r_out.empty_flags       <= empty;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

endmodule

### src/slqs_checker.sv
// Port-level checks for the sparse LED quadrant scanner, bound to the top level.
// Depends on slqs_pkg and sparse_led_quadrant_scanner.
`timescale 1ns / 1ps

module slqs_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input slqs_pkg::t_in_item  i_in_item,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input slqs_pkg::t_out_item o_out_item
);

    import slqs_pkg::*;

    // reset leaves the block in its bitmap clear with nothing to show
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall && !o_out_valid)
        else $error("input not stalled or output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_out_item))
        else $error("stalled output item changed");

    // an empty quadrant shows a dark port, except under the corner pattern
    a_empty_tl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.empty_flags[0] |-> o_out_item.port_top_left == '0)
        else $error("empty top-left quadrant drives a lit position");

    a_empty_br: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.empty_flags[3] |->
            o_out_item.port_bottom_right == '0 ||
            o_out_item.port_bottom_right == C_CORNER_BR)
        else $error("empty bottom-right quadrant drives a lit position");

endmodule

bind sparse_led_quadrant_scanner slqs_checker u_slqs_checker (.*);
